// File: rtl/block_table_heap_allocator_core_assert.svh
// Assertion macros used by the datapath (bta_dp) of the block table heap allocator RTL.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define BTA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bta: same-cycle check failed");
// next-cycle implication
`define BTA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bta: next-cycle check failed");
`else
`define BTA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BTA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/bta_pkg.sv
// Package: constants, codes and control structs of the block table heap allocator.
package bta_pkg;

	localparam int MAX_BLOCKS    = 1024;
	localparam int BLOCK_BYTES   = 4096;
	localparam int IDX_W         = $clog2(MAX_BLOCKS);
	localparam int CNT_W         = IDX_W + 1;
	localparam int BLK_SH        = $clog2(BLOCK_BYTES);
	localparam int ADDR_W        = 32;
	localparam int BLK_NUM_W     = ADDR_W - BLK_SH;
	localparam int NEED_W        = ADDR_W + 1 - BLK_SH;
	localparam int BIU_W         = 11;
	localparam int BLOCKS_RESET  = 1024;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 32;
	localparam int ENTRY_W       = 2;
	localparam int MARK_TAKEN    = 0;
	localparam int MARK_NEXT     = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE   = 1'b0,
		CFG_BLOCKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD      = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    clr;
		logic    scan_init;
		logic    scan;
		logic    fill;
		logic    free_init;
		logic    free;
		logic    emit;
		status_t code;
	} bta_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic is_free;
		logic size_zero;
		logic too_big;
		logic bad_addr;
		logic found;
		logic exhausted;
		logic fill_last;
		logic chain_more;
		logic out_free;
	} bta_stat_t;

endpackage

// File: rtl/bta_req_if.sv
// Request channel interface: valid/ready plus request word.
interface bta_req_if;
	import bta_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [ADDR_W-1:0]   size_bytes;
	logic [ADDR_W-1:0]   address;

	modport source (output valid, req_type, size_bytes, address, input ready);
	modport sink   (input valid, req_type, size_bytes, address, output ready);
endinterface

// File: rtl/bta_rsp_if.sv
// Response channel interface: valid/ready plus result word.
interface bta_rsp_if;
	import bta_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	logic [1:0]          status;

	modport source (output valid, result_address, status, input ready);
	modport sink   (input valid, result_address, status, output ready);
endinterface

// File: rtl/bta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bta_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bta_ctrl.sv
// Controller: sequences the clearing pass after reset, and scan, fill, free and response for each request.
module bta_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bta_pkg::bta_stat_t stat,
	output bta_pkg::bta_cmd_t  cmd
);
	import bta_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_DECODE = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_FILL   = 7'b0010000,
		S_FREE   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_free) begin
					if (stat.bad_addr) begin
						code_d  = ST_BAD;
						state_d = S_RESP;
					end else begin
						cmd.free_init = 1'b1;
						state_d       = S_FREE;
					end
				end else if (stat.size_zero) begin
					code_d  = ST_BAD;
					state_d = S_RESP;
				end else if (stat.too_big) begin
					code_d  = ST_NO_SPACE;
					state_d = S_RESP;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_d = S_FILL;
				end else if (stat.exhausted) begin
					code_d  = ST_NO_SPACE;
					state_d = S_RESP;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					code_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_FREE: begin
				cmd.free = 1'b1;
				if (!stat.chain_more) begin
					code_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

// File: rtl/bta_dp.sv
// Datapath: config registers, block table RAM, scan/fill/free counters, result register.
`include "block_table_heap_allocator_core_assert.svh"
module bta_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bta_pkg::bta_cmd_t                cmd,
	output bta_pkg::bta_stat_t               stat,
	input  logic                             in_req_type,
	input  logic [bta_pkg::ADDR_W-1:0]       in_size_bytes,
	input  logic [bta_pkg::ADDR_W-1:0]       in_address,
	input  logic                             cfg_write,
	input  logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bta_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [bta_pkg::ADDR_W-1:0]       out_result_address,
	output logic [1:0]                       out_status
);
	import bta_pkg::*;

	// configuration
	logic [ADDR_W-1:0]    base_q;
	logic [BIU_W-1:0]     blocks_q;

	// request word
	req_kind_t            req_type_q;
	logic                 size_zero_q;
	logic [NEED_W-1:0]    need_q;
	logic [ADDR_W-1:0]    addr_q;

	// counters
	logic [IDX_W-1:0]     clr_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [CNT_W-1:0]     run_q;
	logic [IDX_W-1:0]     start_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [CNT_W-1:0]     left_q;
	logic [IDX_W-1:0]     fidx_q;

	// result register
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	status_t              out_status_q;

	// RAM port
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [ENTRY_W-1:0]   ram_rdata;

	// derived values
	logic [CNT_W-1:0]     n_blocks;
	logic [ADDR_W:0]      size_sum;
	logic [NEED_W-1:0]    need_in;
	logic [BLK_NUM_W-1:0] abase_blk;
	logic [ADDR_W-1:0]    off;
	logic [BLK_NUM_W-1:0] off_blk;
	logic                 issue;
	logic [CNT_W-1:0]     run_inc;
	logic                 hit;
	logic [CNT_W-1:0]     hit_start;
	logic [CNT_W-1:0]     fidx_inc;
	logic                 chain_more;
	logic [ADDR_W-1:0]    run_addr;
	logic                 out_free;

	bta_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// heap size is the smaller of the register and the table
	assign n_blocks = (32'(blocks_q) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_q);

	// round byte size up to whole blocks
	assign size_sum  = {1'b0, in_size_bytes} + (ADDR_W+1)'(BLOCK_BYTES - 1);
	assign need_in   = size_sum[ADDR_W:BLK_SH];

	// address arithmetic, wraps modulo 2^32
	assign abase_blk = base_q[ADDR_W-1:BLK_SH];
	assign off       = addr_q - {abase_blk, BLK_SH'(0)};
	assign off_blk   = off[ADDR_W-1:BLK_SH];
	assign run_addr  = {abase_blk + BLK_NUM_W'(start_q), BLK_SH'(0)};

	// first-fit scan: each read is checked in the cycle after it is issued
	assign issue     = rd_idx_q < n_blocks;
	assign run_inc   = run_q + CNT_W'(1);
	assign hit       = pend_s1 && !ram_rdata[MARK_TAKEN] && (run_inc == need_q[CNT_W-1:0]);
	assign hit_start = CNT_W'(idx_s1) + CNT_W'(1) - need_q[CNT_W-1:0];

	// chain walk for free
	assign fidx_inc   = CNT_W'(fidx_q) + CNT_W'(1);
	assign chain_more = ram_rdata[MARK_NEXT] && (fidx_inc < n_blocks);

	assign out_free = !out_valid_q || out_ready;

	// status to controller
	always_comb begin
		stat            = '0;
		stat.clear_last = (clr_q == IDX_W'(MAX_BLOCKS - 1));
		stat.is_free    = (req_type_q == REQ_FREE);
		stat.size_zero  = size_zero_q;
		stat.too_big    = (ADDR_W+1)'(need_q) > (ADDR_W+1)'(n_blocks);
		stat.bad_addr   = (ADDR_W+1)'(off_blk) >= (ADDR_W+1)'(n_blocks);
		stat.found      = hit;
		stat.exhausted  = !pend_s1 && !issue;
		stat.fill_last  = (left_q == CNT_W'(1));
		stat.chain_more = chain_more;
		stat.out_free   = out_free;
	end

	// table port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = rd_idx_q[IDX_W-1:0];
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end
		if (cmd.fill) begin
			ram_we                = 1'b1;
			ram_waddr             = wr_idx_q;
			ram_wdata[MARK_TAKEN] = 1'b1;
			ram_wdata[MARK_NEXT]  = (left_q != CNT_W'(1));
		end
		if (cmd.free_init) begin
			ram_raddr = off_blk[IDX_W-1:0];
		end
		if (cmd.free) begin
			ram_we    = 1'b1;
			ram_waddr = fidx_q;
			ram_raddr = fidx_inc[IDX_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			blocks_q <= BIU_W'(BLOCKS_RESET);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BASE:   base_q   <= cfg_data[ADDR_W-1:0];
				CFG_BLOCKS: blocks_q <= cfg_data[BIU_W-1:0];
				default:    ;
			endcase
		end
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			rd_idx_q    <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + IDX_W'(1);
			if (cmd.scan_init) begin
				rd_idx_q <= '0;
				run_q    <= '0;
				pend_s1  <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= issue;
				if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (pend_s1) run_q <= ram_rdata[MARK_TAKEN] ? '0 : run_inc;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, run and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q  <= req_kind_t'(in_req_type);
			size_zero_q <= (in_size_bytes == '0);
			need_q      <= need_in;
			addr_q      <= in_address;
		end
		if (cmd.scan) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.scan && hit) begin
			start_q  <= hit_start[IDX_W-1:0];
			wr_idx_q <= hit_start[IDX_W-1:0];
			left_q   <= need_q[CNT_W-1:0];
		end
		if (cmd.fill) begin
			wr_idx_q <= wr_idx_q + IDX_W'(1);
			left_q   <= left_q - CNT_W'(1);
		end
		if (cmd.free_init) begin
			fidx_q <= off_blk[IDX_W-1:0];
		end
		if (cmd.free && chain_more) begin
			fidx_q <= fidx_inc[IDX_W-1:0];
		end
		if (cmd.emit) begin
			out_status_q <= cmd.code;
			out_addr_q   <= (cmd.code == ST_DONE && req_type_q == REQ_ALLOC) ? run_addr : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_result_address = out_addr_q;
	assign out_status         = out_status_q;

	// a result is only loaded into a free output slot
	`BTA_ASSERT_IMP(a_emit_slot_free, clk, arst_n, cmd.emit, out_free)
	// a loaded result is presented on the next cycle
	`BTA_ASSERT_NXT(a_emit_shows, clk, arst_n, cmd.emit, out_valid_q)
	// the fill never runs past the end of the run
	`BTA_ASSERT_IMP(a_fill_left, clk, arst_n, cmd.fill, left_q != '0)
	// the free-run counter stays below the requested length while scanning
	`BTA_ASSERT_IMP(a_scan_run, clk, arst_n, cmd.scan, run_q < need_q[CNT_W-1:0])

endmodule

// File: rtl/block_table_heap_allocator_core.sv
// Top level of the first-fit block table heap allocator.
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-----------------------------------
//  req     | in  | valid/ready       | req_type, size_bytes, address
//  rsp     | out | valid/ready       | result_address, status
//  cfg     | in  | cfg_write         | cfg_index, cfg_data
//
// After reset a clearing pass writes all 1024 table entries,
// during which no request word is taken.
// Allocate: take and decode, then a first-fit scan (one table read per cycle),
// then a fill that marks each block of the run, then the response.
// Free: take and decode, then walk and clear the chain entries, then the response.
// The response sits in an output register; a new request is taken while it
// waits, but its own response is held back until that register drains.
module block_table_heap_allocator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	bta_req_if.sink                          req,
	bta_rsp_if.source                        rsp,
	input  logic                             cfg_write,
	input  logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bta_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bta_pkg::*;

	bta_cmd_t  cmd;
	bta_stat_t stat;

	bta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bta_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.in_req_type        (req.req_type),
		.in_size_bytes      (req.size_bytes),
		.in_address         (req.address),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_ready          (rsp.ready),
		.out_valid          (rsp.valid),
		.out_result_address (rsp.result_address),
		.out_status         (rsp.status)
	);

endmodule

// File: tb/sv/block_table_heap_allocator_core_test.sv
// Self-checking testbench for the first-fit block table heap allocator core.
`timescale 1ns / 1ps

module block_table_heap_allocator_core_test;
	import bta_pkg::*;

	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 44;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} heap_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bta_req_if req_ch();
	bta_rsp_if rsp_ch();

	block_table_heap_allocator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the block table and registers
	logic [ENTRY_W-1:0] shadow_table [MAX_BLOCKS];
	logic [ADDR_W-1:0]  shadow_base;
	logic [BIU_W-1:0]   shadow_blocks;

	heap_reply_t pending_replies[$];
	int unsigned live_blocks[$];
	heap_reply_t want;

	// idling controls
	bit          quiet;
	int unsigned req_gap_pct;
	int unsigned rsp_stall_pct;
	int unsigned stall_left = 0;

	// bookkeeping
	int unsigned mismatches  = 0;
	int unsigned reply_cnt   = 0;
	int unsigned sent_cnt    = 0;
	int unsigned settings    = 1;
	int unsigned placed_cnt  = 0;
	int unsigned freed_cnt   = 0;
	int unsigned full_cnt    = 0;
	int unsigned reject_cnt  = 0;
	int unsigned cycle_cnt   = 0;

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// heap predictor
	// ---------------------------------------------------------------
	function automatic int unsigned heap_size();
		return (shadow_blocks > MAX_BLOCKS) ? MAX_BLOCKS : shadow_blocks;
	endfunction

	function automatic logic [ADDR_W-1:0] heap_origin();
		return {shadow_base[ADDR_W-1:BLK_SH], {BLK_SH{1'b0}}};
	endfunction

	function automatic heap_reply_t predict_alloc(logic [ADDR_W-1:0] size);
		heap_reply_t r;
		int unsigned n;
		int unsigned run;
		int unsigned first;
		longint unsigned need;
		bit hit;
		n = heap_size();
		r.addr = '0;
		r.st = ST_DONE;
		run = 0;
		first = 0;
		hit = 1'b0;
		need = ({32'd0, size} + 64'(BLOCK_BYTES - 1)) >> BLK_SH;
		if (size == 0)
			r.st = ST_BAD;
		else if (need > 64'(n))
			r.st = ST_NO_SPACE;
		else begin
			// first-fit scan for a free run
			for (int i = 0; i < n && !hit; i++) begin
				if (shadow_table[i][MARK_TAKEN])
					run = 0;
				else begin
					run++;
					if (run == need) begin
						first = i + 1 - run;
						hit = 1'b1;
					end
				end
			end
			if (!hit)
				r.st = ST_NO_SPACE;
			else begin
				// mark the run as one chain
				for (int i = first; i < first + run; i++) begin
					shadow_table[i] = '0;
					shadow_table[i][MARK_TAKEN] = 1'b1;
					shadow_table[i][MARK_NEXT] = (i + 1 < first + run);
				end
				r.addr = heap_origin() + first * BLOCK_BYTES;
			end
		end
		return r;
	endfunction

	function automatic heap_reply_t predict_free(logic [ADDR_W-1:0] addr);
		heap_reply_t r;
		int unsigned n;
		logic [ADDR_W-1:0] off;
		logic [ENTRY_W-1:0] entry;
		bit stop;
		n = heap_size();
		off = addr - heap_origin();
		r.addr = '0;
		r.st = ST_DONE;
		stop = 1'b0;
		if ({32'd0, off} >= 64'(n) * 64'(BLOCK_BYTES))
			r.st = ST_BAD;
		else begin
			// walk the chain, never past the heap end
			for (int i = off >> BLK_SH; i < n && !stop; i++) begin
				entry = shadow_table[i];
				shadow_table[i] = '0;
				stop = !entry[MARK_NEXT];
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic send_word(input req_kind_t kind, input logic [ADDR_W-1:0] size,
			input logic [ADDR_W-1:0] addr);
		heap_reply_t r;
		if (!quiet && req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.size_bytes <= size;
		req_ch.address    <= addr;
		do @(posedge clk); while (!req_ch.ready);
		// word taken at this edge
		if (kind == REQ_ALLOC)
			r = predict_alloc(size);
		else
			r = predict_free(addr);
		pending_replies.push_back(r);
		sent_cnt++;
		if (r.st == ST_BAD)
			reject_cnt++;
		else if (r.st == ST_NO_SPACE)
			full_cnt++;
		else if (kind == REQ_ALLOC) begin
			placed_cnt++;
			live_blocks.push_back((r.addr - heap_origin()) >> BLK_SH);
		end else
			freed_cnt++;
	endtask

	// drop valid and wait until every reply is back and the core is idle
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [ADDR_W-1:0] base, input logic [CFG_DATA_W-1:0] blocks);
		cfg_write <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data  <= base;
		@(posedge clk);
		shadow_base = base;
		cfg_index <= CFG_BLOCKS;
		cfg_data  <= blocks;
		@(posedge clk);
		shadow_blocks = blocks[BIU_W-1:0];
		cfg_write <= 1'b0;
		settings++;
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned n;
		int unsigned span;
		int unsigned k;
		int unsigned blk;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		n = heap_size();
		pick = $urandom_range(0, 99);
		size = $urandom;
		addr = $urandom;
		if (pick < 50 || (pick < 88 && live_blocks.size() == 0)) begin
			// allocation of one to six blocks, now and then of up to the whole heap
			span = ($urandom_range(0, 19) == 0 && n > 0) ? $urandom_range(1, n)
				: $urandom_range(1, 6);
			size = (span - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
			send_word(REQ_ALLOC, size, addr);
		end else if (pick < 88) begin
			// release a run handed out earlier, sometimes at an inner byte
			k = $urandom_range(0, live_blocks.size() - 1);
			blk = live_blocks[k];
			live_blocks.delete(k);
			addr = heap_origin() + blk * BLOCK_BYTES
				+ (($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCK_BYTES - 1) : 0);
			send_word(REQ_FREE, size, addr);
		end else if (pick < 92)
			send_word(REQ_ALLOC, '0, addr);
		else if (pick < 95)
			send_word(REQ_ALLOC, size, addr);
		else if (pick < 98)
			send_word(REQ_FREE, size, addr);
		else
			// any block start, free or mid-chain, or one past the end
			send_word(REQ_FREE, size, heap_origin() + $urandom_range(0, n) * BLOCK_BYTES);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	task automatic test_first_fit();
		send_word(REQ_ALLOC, 32'd1, $urandom);
		send_word(REQ_ALLOC, 32'd4096, $urandom);
		send_word(REQ_ALLOC, 32'd4097, $urandom);
		// unaligned free inside a two-block chain
		send_word(REQ_FREE, $urandom, 32'h0000_2123);
		// free of a block that is already free
		send_word(REQ_FREE, $urandom, 32'h0000_3000);
		// hole left by the chain gets reused
		send_word(REQ_ALLOC, 32'd8192, $urandom);
		send_word(REQ_FREE, $urandom, 32'h0000_1000);
		// trailing run too short for the whole heap
		send_word(REQ_ALLOC, 32'h0040_0000, $urandom);
	endtask

	task automatic test_bad_requests();
		send_word(REQ_ALLOC, 32'd0, $urandom);
		send_word(REQ_ALLOC, 32'hFFFF_FFFF, $urandom);
		// first byte past the heap
		send_word(REQ_FREE, $urandom, 32'h0040_0000);
	endtask

	task automatic test_full_heap();
		send_word(REQ_FREE, $urandom, 32'h0000_0000);
		send_word(REQ_FREE, $urandom, 32'h0000_2000);
		send_word(REQ_ALLOC, 32'h0040_0000, $urandom);
		send_word(REQ_ALLOC, 32'd1, $urandom);
		// last byte of the heap, tail of the chain
		send_word(REQ_FREE, $urandom, 32'h003F_FFFF);
		send_word(REQ_ALLOC, 32'd4096, $urandom);
		send_word(REQ_FREE, $urandom, 32'h0000_0000);
	endtask

	task automatic test_wrapped_base();
		settle();
		write_config(32'hFFFF_F123, 32'd3);
		send_word(REQ_ALLOC, 32'd1, $urandom);
		// run address wraps past the top of the address space
		send_word(REQ_ALLOC, 32'd8192, $urandom);
		send_word(REQ_FREE, $urandom, 32'h0000_1FFF);
		send_word(REQ_FREE, $urandom, 32'h0000_0000);
	endtask

	task automatic test_shrunk_heap();
		settle();
		write_config(32'h0000_0000, 32'd8);
		send_word(REQ_ALLOC, 32'd28672, $urandom);
		settle();
		// chain now runs past the heap end; clearing stops there
		write_config(32'h0000_0000, 32'd4);
		send_word(REQ_FREE, $urandom, 32'h0000_1000);
		settle();
		write_config(32'h0000_0000, 32'd8);
		send_word(REQ_ALLOC, 32'd12288, $urandom);
		send_word(REQ_FREE, $urandom, 32'h0000_4000);
	endtask

	task automatic test_empty_heap();
		settle();
		write_config(32'h1234_5000, 32'd0);
		send_word(REQ_ALLOC, 32'd1, $urandom);
		send_word(REQ_FREE, $urandom, 32'h1234_5000);
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin
					write_config($urandom, 32'd1024);
					req_gap_pct = 20;
					rsp_stall_pct = 10;
				end
				1: begin
					write_config($urandom, $urandom_range(4, 40));
					req_gap_pct = 0;
					rsp_stall_pct = 25;
				end
				2: begin
					// single-block heap, junk above the register width
					write_config(32'hFFFF_FFFF, {21'($urandom), 11'd1});
					req_gap_pct = 30;
					rsp_stall_pct = 0;
				end
				3: begin
					// count beyond the table, clamped to the table size
					write_config(32'h0000_0000, {21'($urandom), 11'd2047});
					req_gap_pct = 10;
					rsp_stall_pct = 5;
				end
				4: begin
					write_config($urandom, $urandom_range(1, 1024));
					req_gap_pct = 50;
					rsp_stall_pct = 40;
				end
				default: begin
					write_config($urandom, 32'd16);
					quiet = 1'b1;
				end
			endcase
			repeat (PHASE_ITEMS) random_item();
		end
	endtask

	// ---------------------------------------------------------------
	// reply ready: random stall bursts
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= (stall_left == 1);
		end else if (!quiet && rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
			stall_left <= $urandom_range(1, 13);
			rsp_ch.ready <= 1'b0;
		end else
			rsp_ch.ready <= 1'b1;
	end

	// reply checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			reply_cnt++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply %0d with none pending: addr %h status %0d",
						reply_cnt, rsp_ch.result_address, rsp_ch.status);
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.result_address !== want.addr || rsp_ch.status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply %0d: expected addr %h status %0d, got addr %h status %0d",
							reply_cnt, want.addr, want.st, rsp_ch.result_address,
							rsp_ch.status);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = CFG_BASE;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_ALLOC;
		req_ch.size_bytes = '0;
		req_ch.address    = '0;
		rsp_ch.ready      = 1'b0;
		quiet             = 1'b0;
		req_gap_pct       = 15;
		rsp_stall_pct     = 15;
		for (int i = 0; i < MAX_BLOCKS; i++)
			shadow_table[i] = '0;
		shadow_base   = '0;
		shadow_blocks = BIU_W'(BLOCKS_RESET);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_first_fit();
		test_bad_requests();
		test_full_heap();
		test_wrapped_base();
		test_shrunk_heap();
		test_empty_heap();
		test_random_traffic();

		settle();
		repeat (64) @(posedge clk);
		$display("%0d requests over %0d heap settings: %0d runs placed, %0d frees done",
			sent_cnt, settings, placed_cnt, freed_cnt);
		$display("%0d out of space, %0d rejected, %0d replies checked, %0d mismatches",
			full_cnt, reject_cnt, reply_cnt, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/bta_pkg.sv
rtl/bta_req_if.sv
rtl/bta_rsp_if.sv
rtl/bta_ram.sv
rtl/bta_ctrl.sv
rtl/bta_dp.sv
rtl/block_table_heap_allocator_core.sv
tb/sv/block_table_heap_allocator_core_test.sv
